@@ rtl/camellia_block_cipher_macros.svh @@
// assertion macros shared by the checker
`ifndef CAMELLIA_BLOCK_CIPHER_MACROS_SVH
`define CAMELLIA_BLOCK_CIPHER_MACROS_SVH

// implication checked on every clock edge outside reset
`define CBC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked on every clock edge outside reset
`define CBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/cbc_pkg.sv @@
`default_nettype none
package cbc_pkg;

    typedef struct packed {
        logic        operation;
        logic [5:0]  subkey_index;
        logic [63:0] subkey_value;
        logic [63:0] block_hi;
        logic [63:0] block_lo;
        logic        decrypt;
    } in_item_t;

    typedef struct packed {
        logic [63:0] result_hi;
        logic [63:0] result_lo;
    } out_item_t;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_BLOCK = 1'b1;

    localparam logic [0:0] REG_LONG_KEY_MODE = 1'b0;

    // datapath step codes
    typedef enum logic [2:0] {
        STEP_IDLE,
        STEP_LOAD,
        STEP_PRE,
        STEP_ROUND,
        STEP_FL,
        STEP_POST
    } step_t;

    // command from controller to datapath
    typedef struct packed {
        step_t      step;
        logic [5:0] key_a;
        logic [5:0] key_b;
        logic       swap_fl;
        logic       right_side;
    } cmd_t;

    typedef logic [7:0] sbox_table_t [256];

    localparam sbox_table_t SBOX1 = '{
        8'h70,8'h82,8'h2c,8'hec,8'hb3,8'h27,8'hc0,8'he5,8'he4,8'h85,8'h57,8'h35,8'hea,8'h0c,8'hae,8'h41,
        8'h23,8'hef,8'h6b,8'h93,8'h45,8'h19,8'ha5,8'h21,8'hed,8'h0e,8'h4f,8'h4e,8'h1d,8'h65,8'h92,8'hbd,
        8'h86,8'hb8,8'haf,8'h8f,8'h7c,8'heb,8'h1f,8'hce,8'h3e,8'h30,8'hdc,8'h5f,8'h5e,8'hc5,8'h0b,8'h1a,
        8'ha6,8'he1,8'h39,8'hca,8'hd5,8'h47,8'h5d,8'h3d,8'hd9,8'h01,8'h5a,8'hd6,8'h51,8'h56,8'h6c,8'h4d,
        8'h8b,8'h0d,8'h9a,8'h66,8'hfb,8'hcc,8'hb0,8'h2d,8'h74,8'h12,8'h2b,8'h20,8'hf0,8'hb1,8'h84,8'h99,
        8'hdf,8'h4c,8'hcb,8'hc2,8'h34,8'h7e,8'h76,8'h05,8'h6d,8'hb7,8'ha9,8'h31,8'hd1,8'h17,8'h04,8'hd7,
        8'h14,8'h58,8'h3a,8'h61,8'hde,8'h1b,8'h11,8'h1c,8'h32,8'h0f,8'h9c,8'h16,8'h53,8'h18,8'hf2,8'h22,
        8'hfe,8'h44,8'hcf,8'hb2,8'hc3,8'hb5,8'h7a,8'h91,8'h24,8'h08,8'he8,8'ha8,8'h60,8'hfc,8'h69,8'h50,
        8'haa,8'hd0,8'ha0,8'h7d,8'ha1,8'h89,8'h62,8'h97,8'h54,8'h5b,8'h1e,8'h95,8'he0,8'hff,8'h64,8'hd2,
        8'h10,8'hc4,8'h00,8'h48,8'ha3,8'hf7,8'h75,8'hdb,8'h8a,8'h03,8'he6,8'hda,8'h09,8'h3f,8'hdd,8'h94,
        8'h87,8'h5c,8'h83,8'h02,8'hcd,8'h4a,8'h90,8'h33,8'h73,8'h67,8'hf6,8'hf3,8'h9d,8'h7f,8'hbf,8'he2,
        8'h52,8'h9b,8'hd8,8'h26,8'hc8,8'h37,8'hc6,8'h3b,8'h81,8'h96,8'h6f,8'h4b,8'h13,8'hbe,8'h63,8'h2e,
        8'he9,8'h79,8'ha7,8'h8c,8'h9f,8'h6e,8'hbc,8'h8e,8'h29,8'hf5,8'hf9,8'hb6,8'h2f,8'hfd,8'hb4,8'h59,
        8'h78,8'h98,8'h06,8'h6a,8'he7,8'h46,8'h71,8'hba,8'hd4,8'h25,8'hab,8'h42,8'h88,8'ha2,8'h8d,8'hfa,
        8'h72,8'h07,8'hb9,8'h55,8'hf8,8'hee,8'hac,8'h0a,8'h36,8'h49,8'h2a,8'h68,8'h3c,8'h38,8'hf1,8'ha4,
        8'h40,8'h28,8'hd3,8'h7b,8'hbb,8'hc9,8'h43,8'hc1,8'h15,8'he3,8'had,8'hf4,8'h77,8'hc7,8'h80,8'h9e
    };

    function automatic logic [7:0] rotl8(input logic [7:0] v);
        return {v[6:0], v[7]};
    endfunction

    function automatic logic [7:0] s1(input logic [7:0] v);
        return SBOX1[v];
    endfunction

    function automatic logic [7:0] s2(input logic [7:0] v);
        return rotl8(SBOX1[v]);
    endfunction

    function automatic logic [7:0] s3(input logic [7:0] v);
        logic [7:0] a;
        a = SBOX1[v];
        return {a[0], a[7:1]};
    endfunction

    function automatic logic [7:0] s4(input logic [7:0] v);
        return SBOX1[rotl8(v)];
    endfunction

    // round function: s-box layer then p-layer
    function automatic logic [63:0] f_func(input logic [63:0] x);
        logic [7:0] t1, t2, t3, t4, t5, t6, t7, t8;
        logic [7:0] y1, y2, y3, y4, y5, y6, y7, y8;
        t1 = s1(x[63:56]);
        t2 = s2(x[55:48]);
        t3 = s3(x[47:40]);
        t4 = s4(x[39:32]);
        t5 = s2(x[31:24]);
        t6 = s3(x[23:16]);
        t7 = s4(x[15:8]);
        t8 = s1(x[7:0]);
        y1 = t1 ^ t3 ^ t4 ^ t6 ^ t7 ^ t8;
        y2 = t1 ^ t2 ^ t4 ^ t5 ^ t7 ^ t8;
        y3 = t1 ^ t2 ^ t3 ^ t5 ^ t6 ^ t8;
        y4 = t2 ^ t3 ^ t4 ^ t5 ^ t6 ^ t7;
        y5 = t1 ^ t2 ^ t6 ^ t7 ^ t8;
        y6 = t2 ^ t3 ^ t5 ^ t7 ^ t8;
        y7 = t3 ^ t4 ^ t5 ^ t6 ^ t8;
        y8 = t1 ^ t4 ^ t5 ^ t6 ^ t7;
        return {y1, y2, y3, y4, y5, y6, y7, y8};
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] v);
        return {v[30:0], v[31]};
    endfunction

    function automatic logic [63:0] fl(input logic [63:0] v, input logic [63:0] k);
        logic [31:0] x1, x2;
        x1 = v[63:32];
        x2 = v[31:0];
        x2 = x2 ^ rotl32(x1 & k[63:32]);
        x1 = x1 ^ (x2 | k[31:0]);
        return {x1, x2};
    endfunction

    function automatic logic [63:0] fl_inv(input logic [63:0] v, input logic [63:0] k);
        logic [31:0] x1, x2;
        x1 = v[63:32];
        x2 = v[31:0];
        x1 = x1 ^ (x2 | k[31:0]);
        x2 = x2 ^ rotl32(x1 & k[63:32]);
        return {x1, x2};
    endfunction

endpackage
`default_nettype wire

@@ rtl/cbc_ctrl.sv @@
`default_nettype none
module cbc_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire logic           operation,
    input  wire logic           decrypt,
    input  wire logic           long_key_mode,
    input  wire logic           out_busy,
    output logic                in_ready,
    output cbc_pkg::cmd_t       cmd,
    output logic [5:0]          rd_key_a,
    output logic [5:0]          rd_key_b,
    output logic                done
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRE,
        S_ROUND,
        S_FL,
        S_POST,
        S_WAIT
    } state_t;

    state_t      state_reg, state_next;
    logic [2:0]  group_reg, group_next;
    logic [2:0]  round_reg, round_next;
    logic [2:0]  groups_reg, groups_next;
    logic        dec_reg, dec_next;

    // subkey positions used by one step
    function automatic logic [11:0] step_keys(input state_t st, input logic [2:0] grp,
                                              input logic [2:0] rnd, input logic [2:0] gs,
                                              input logic dec);
        logic [5:0] g8;
        logic [5:0] gmax8;
        logic [5:0] rkey;
        logic [5:0] k_a;
        logic [5:0] k_b;
        g8    = {grp, 3'b000};
        gmax8 = {gs, 3'b000};
        // encrypt walks forward through the group, decrypt backward
        rkey  = dec ? (g8 + 6'd7 - {3'b000, rnd}) : (g8 + 6'd2 + {3'b000, rnd});
        k_a   = 6'd0;
        k_b   = 6'd0;
        unique case (st)
            S_PRE:
            begin
                k_a = dec ? gmax8 + 6'd1 : 6'd0;
                k_b = dec ? gmax8 : 6'd1;
            end
            S_ROUND:
            begin
                k_a = rkey;
            end
            S_FL:
            begin
                k_a = dec ? g8 + 6'd1 : g8;
                k_b = dec ? g8 : g8 + 6'd1;
            end
            S_POST:
            begin
                k_a = dec ? 6'd1 : gmax8 + 6'd1;
                k_b = dec ? 6'd0 : gmax8;
            end
            default:
            begin
                k_a = 6'd0;
                k_b = 6'd0;
            end
        endcase
        return {k_a, k_b};
    endfunction

    assign in_ready = (state_reg == S_IDLE);

    // store addresses for the coming step, read in the cycle before it
    assign {rd_key_a, rd_key_b} = step_keys(state_next, group_next, round_next,
                                            groups_next, dec_next);

    // command decode
    always_comb
    begin
        cmd = '0;
        cmd.step = cbc_pkg::STEP_IDLE;
        {cmd.key_a, cmd.key_b} = step_keys(state_reg, group_reg, round_reg,
                                           groups_reg, dec_reg);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && operation == cbc_pkg::OP_LOAD)
                    cmd.step = cbc_pkg::STEP_LOAD;
            end
            S_PRE:
            begin
                cmd.step = cbc_pkg::STEP_PRE;
            end
            S_ROUND:
            begin
                cmd.step       = cbc_pkg::STEP_ROUND;
                cmd.right_side = round_reg[0];
            end
            S_FL:
            begin
                cmd.step    = cbc_pkg::STEP_FL;
                cmd.swap_fl = dec_reg;
            end
            S_POST:
            begin
                cmd.step = cbc_pkg::STEP_POST;
            end
            S_WAIT:
            begin
                cmd.step = cbc_pkg::STEP_IDLE;
            end
            default:
            begin
                cmd.step = cbc_pkg::STEP_IDLE;
            end
        endcase
    end

    // sequencing
    always_comb
    begin
        state_next  = state_reg;
        group_next  = group_reg;
        round_next  = round_reg;
        groups_next = groups_reg;
        dec_next    = dec_reg;
        done        = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && operation == cbc_pkg::OP_BLOCK)
                begin
                    groups_next = long_key_mode ? 3'd4 : 3'd3;
                    dec_next    = decrypt;
                    state_next  = S_PRE;
                end
            end
            S_PRE:
            begin
                group_next = dec_reg ? groups_reg - 3'd1 : 3'd0;
                round_next = 3'd0;
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                round_next = round_reg + 3'd1;
                if (round_reg == 3'd5)
                begin
                    round_next = 3'd0;
                    if (dec_reg)
                    begin
                        if (group_reg == 3'd0)
                            state_next = S_POST;
                        else
                            state_next = S_FL;
                    end
                    else
                    begin
                        if (group_reg == groups_reg - 3'd1)
                            state_next = S_POST;
                        else
                        begin
                            group_next = group_reg + 3'd1;
                            state_next = S_FL;
                        end
                    end
                end
            end
            S_FL:
            begin
                if (dec_reg)
                    group_next = group_reg - 3'd1;
                state_next = S_ROUND;
            end
            S_POST:
            begin
                state_next = out_busy ? S_WAIT : S_IDLE;
                if (!out_busy)
                    done = 1'b1;
            end
            S_WAIT:
            begin
                if (!out_busy)
                begin
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            group_reg  <= '0;
            round_reg  <= '0;
            groups_reg <= 3'd3;
            dec_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            group_reg  <= group_next;
            round_reg  <= round_next;
            groups_reg <= groups_next;
            dec_reg    <= dec_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/cbc_datapath.sv @@
`default_nettype none
module cbc_datapath #(
    parameter int SUBKEY_DEPTH = 34
) (
    input  wire logic              clk,
    input  wire cbc_pkg::cmd_t     cmd,
    input  wire logic [5:0]        rd_key_a,
    input  wire logic [5:0]        rd_key_b,
    input  wire cbc_pkg::in_item_t in_item,
    input  wire logic              start,
    output cbc_pkg::out_item_t     result
);

    localparam int AW = $clog2(SUBKEY_DEPTH);

    // subkey store, contents undefined until loaded
    logic [63:0] store [SUBKEY_DEPTH];
    logic [63:0] l_reg, l_next;
    logic [63:0] r_reg, r_next;
    logic [63:0] ka_reg;
    logic [63:0] kb_reg;

    // load and registered read, positions at or above the depth read as zero
    always_ff @(posedge clk)
    begin
        if (cmd.step == cbc_pkg::STEP_LOAD &&
            {26'd0, in_item.subkey_index} < SUBKEY_DEPTH)
            store[in_item.subkey_index[AW-1:0]] <= in_item.subkey_value;
        if ({26'd0, rd_key_a} < SUBKEY_DEPTH)
            ka_reg <= store[rd_key_a[AW-1:0]];
        else
            ka_reg <= '0;
        if ({26'd0, rd_key_b} < SUBKEY_DEPTH)
            kb_reg <= store[rd_key_b[AW-1:0]];
        else
            kb_reg <= '0;
    end

    // one step per cycle on the halves
    always_comb
    begin
        l_next = l_reg;
        r_next = r_reg;
        case (cmd.step)
            cbc_pkg::STEP_PRE:
            begin
                l_next = l_reg ^ (cmd.key_a == 6'd0 ? ka_reg : kb_reg);
                r_next = r_reg ^ (cmd.key_a == 6'd0 ? kb_reg : ka_reg);
            end
            cbc_pkg::STEP_ROUND:
            begin
                if (cmd.right_side)
                    l_next = l_reg ^ cbc_pkg::f_func(r_reg ^ ka_reg);
                else
                    r_next = r_reg ^ cbc_pkg::f_func(l_reg ^ ka_reg);
            end
            cbc_pkg::STEP_FL:
            begin
                l_next = cbc_pkg::fl(l_reg, cmd.swap_fl ? ka_reg : ka_reg);
                r_next = cbc_pkg::fl_inv(r_reg, kb_reg);
            end
            cbc_pkg::STEP_POST:
            begin
                r_next = r_reg ^ kb_reg;
                l_next = l_reg ^ ka_reg;
            end
            default:
            begin
                l_next = l_reg;
                r_next = r_reg;
            end
        endcase
        if (start)
        begin
            l_next = in_item.block_hi;
            r_next = in_item.block_lo;
        end
    end

    always_ff @(posedge clk)
    begin
        l_reg <= l_next;
        r_reg <= r_next;
    end

    // result includes the closing whitening step
    assign result.result_hi = r_next;
    assign result.result_lo = l_next;

endmodule
`default_nettype wire

@@ rtl/camellia_block_cipher.sv @@
// Camellia cipher engine on 128-bit blocks.
// Requests arrive on a valid/ready input channel as one in_item_t. A load
// request (operation 0) writes one 64-bit subkey into the store. A block
// request (operation 1) encrypts or decrypts the block with the stored
// subkeys; every store entry the block uses must be loaded first.
// The long_key_mode register (APB, address 0) picks 18 rounds or 24 rounds.
// A block runs one step per cycle on a single round unit: one whitening
// step, six rounds per group, one FL layer between groups and one closing
// step, after which the result is registered for output. The engine takes
// no new request while a block runs.
// The result sits in an output register with valid/ready; while it stalls
// the engine can take and run one more block, then holds it in a wait state
// and takes no new request until the waiting result is taken.
// Reset clears the control state and the mode register; subkey contents
// are undefined until loaded.
`default_nettype none
module camellia_block_cipher #(
    parameter int SUBKEY_DEPTH = 34
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire cbc_pkg::in_item_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output cbc_pkg::out_item_t      out_data,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [1:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    cbc_pkg::cmd_t      cmd;
    cbc_pkg::out_item_t dp_result;
    logic [5:0]         rd_key_a;
    logic [5:0]         rd_key_b;
    logic               done;
    logic               start;
    logic               mode_reg;
    logic               out_valid_reg;
    cbc_pkg::out_item_t out_data_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[1:0] == 2'(4 * cbc_pkg::REG_LONG_KEY_MODE)) ?
                    {31'd0, mode_reg} : 32'd0;

    // mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= 1'b0;
        else if (psel && penable && pwrite &&
                 paddr == 2'(4 * cbc_pkg::REG_LONG_KEY_MODE))
            mode_reg <= pwdata[0];
    end

    assign start = in_valid && in_ready && in_data.operation == cbc_pkg::OP_BLOCK;

    cbc_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .operation     (in_data.operation),
        .decrypt       (in_data.decrypt),
        .long_key_mode (mode_reg),
        .out_busy      (out_valid_reg && !out_ready),
        .in_ready      (in_ready),
        .cmd           (cmd),
        .rd_key_a      (rd_key_a),
        .rd_key_b      (rd_key_b),
        .done          (done)
    );

    cbc_datapath #(.SUBKEY_DEPTH(SUBKEY_DEPTH)) u_dp (
        .clk      (clk),
        .cmd      (cmd),
        .rd_key_a (rd_key_a),
        .rd_key_b (rd_key_b),
        .in_item  (in_data),
        .start    (start),
        .result   (dp_result)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (done)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (done)
            out_data_reg <= dp_result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire

@@ rtl/cbc_checker.sv @@
`default_nettype none
`include "camellia_block_cipher_macros.svh"
module cbc_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic pready,
    input wire logic block_req
);

    // a stalled result stays offered
    `CBC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    // the engine is busy straight after taking a block request
    `CBC_ASSERT_NEXT(a_busy_after_block, clk, rst_n, in_valid && in_ready && block_req, !in_ready)
    // no result appears the cycle after a block request taken while none is offered
    `CBC_ASSERT_NEXT(a_no_instant_result, clk, rst_n, in_valid && in_ready && block_req && !out_valid, !out_valid)
    // config port never stalls
    `CBC_ASSERT_IMP(a_pready, clk, rst_n, 1'b1, pready)

endmodule

bind camellia_block_cipher cbc_checker u_cbc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pready    (pready),
    .block_req (in_data.operation)
);
`default_nettype wire
